@@ sv/cfpp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfpp_pkg: shared definitions of the contour farthest-point pair block
// Field widths, parameter defaults and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package cfpp_pkg;

	// Width of every coordinate field on the ports.
	localparam int FIELD_W = 12;

	// Defaults for the top-level parameters.
	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 12;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // store and sum the point of the accepted transaction
		logic pass_start; // rewind the read address and clear the best distance
		logic issue;      // read one stored point into the distance pipeline
		logic pass_two;   // distances are taken from edge one, not the centroid
		logic latch_e1;   // the best point of pass one becomes edge one
		logic emit;       // load the result register and start a new contour
	} cfpp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_zero;   // no point is stored
		logic last_issue; // the read address points at the last stored point
		logic pipe_empty; // no point is in flight in the distance pipeline
		logic out_free;   // the result register can take a new result
	} cfpp_stat_t;

endpackage

@@ sv/cfpp_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfpp_ctrl: sequencer of the contour farthest-point pair block
// Steps through loading, the centroid pass, the edge-one pass and the
// hand-off of the result, and commands the datapath accordingly.
// ----------------------------------------------------------------------------
module cfpp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 last_point,
	input  cfpp_pkg::cfpp_stat_t stat,
	output logic                 in_stall,
	output cfpp_pkg::cfpp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_LOAD     = 6'b000001,
		S_P1_RUN   = 6'b000010,
		S_P1_DRAIN = 6'b000100,
		S_P2_RUN   = 6'b001000,
		S_P2_DRAIN = 6'b010000,
		S_EMIT     = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Input transactions are taken only while a contour is being loaded.
	assign in_stall = (state_q != S_LOAD);

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_point) begin
						cmd.pass_start = 1'b1;
						state_nxt      = S_P1_RUN;
					end
				end
			end
			S_P1_RUN: begin
				if (stat.cnt_zero) begin
					state_nxt = S_EMIT;
				end else begin
					cmd.issue = 1'b1;
					if (stat.last_issue) begin
						state_nxt = S_P1_DRAIN;
					end
				end
			end
			S_P1_DRAIN: begin
				if (stat.pipe_empty) begin
					cmd.latch_e1   = 1'b1;
					cmd.pass_start = 1'b1;
					state_nxt      = S_P2_RUN;
				end
			end
			S_P2_RUN: begin
				cmd.pass_two = 1'b1;
				cmd.issue    = 1'b1;
				if (stat.last_issue) begin
					state_nxt = S_P2_DRAIN;
				end
			end
			S_P2_DRAIN: begin
				cmd.pass_two = 1'b1;
				if (stat.pipe_empty) begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_LOAD;
				end
			end
			default: begin
				state_nxt = S_LOAD;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ sv/cfpp_dp.sv @@
// ----------------------------------------------------------------------------
// cfpp_dp: datapath of the contour farthest-point pair block
// Point store, running sums, a five-stage distance pipeline with a running
// maximum, and the result register.
// ----------------------------------------------------------------------------
module cfpp_dp #(
	parameter int MAX_POINTS = cfpp_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = cfpp_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfpp_pkg::cfpp_cmd_t          cmd,
	output cfpp_pkg::cfpp_stat_t         stat,
	input  logic [cfpp_pkg::FIELD_W-1:0] point_x,
	input  logic [cfpp_pkg::FIELD_W-1:0] point_y,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [cfpp_pkg::FIELD_W-1:0] edge_one_x,
	output logic [cfpp_pkg::FIELD_W-1:0] edge_one_y,
	output logic [cfpp_pkg::FIELD_W-1:0] edge_two_x,
	output logic [cfpp_pkg::FIELD_W-1:0] edge_two_y,
	output logic                         empty_flag,
	output logic                         overflow_flag
);

	localparam int FW     = cfpp_pkg::FIELD_W;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int AW     = $clog2(MAX_POINTS);
	localparam int DW     = CNT_W + COORD_BITS;
	localparam int SQF_W  = 2 * DW;
	localparam int SQ_W   = (SQF_W > 64) ? 64 : SQF_W;
	localparam int DST_W  = SQ_W + 1;
	localparam int EXT_W  = (COORD_BITS > FW) ? COORD_BITS : FW;

	// Point store, x in the low half and y in the high half of each entry.
	logic [2*COORD_BITS-1:0] store_q [MAX_POINTS];

	logic [CNT_W-1:0]      cnt_q;
	logic [DW-1:0]         sum_x_q;
	logic [DW-1:0]         sum_y_q;
	logic                  drop_q;
	logic [AW-1:0]         rd_addr_q;

	logic [EXT_W-1:0]      px_ext;
	logic [EXT_W-1:0]      py_ext;
	logic [COORD_BITS-1:0] x_in;
	logic [COORD_BITS-1:0] y_in;
	logic                  room;

	// Pipeline valids and carried flags.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic first_s1, first_s2, first_s3, first_s4, first_s5;

	// Carried coordinates.
	logic [2*COORD_BITS-1:0] rd_s1;
	logic [COORD_BITS-1:0]   x_s2, y_s2, x_s3, y_s3, x_s4, y_s4, x_s5, y_s5;

	// Arithmetic stages.
	logic [DW-1:0]    prod_x_s2, prod_y_s2;
	logic [DW-1:0]    dx_s3, dy_s3;
	logic [SQ_W-1:0]  sqx_s4, sqy_s4;
	logic [DST_W-1:0] dist_s5;

	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [DW-1:0]         prod_x, prod_y, ref_x, ref_y;
	logic [SQF_W-1:0]      sqx_full, sqy_full;
	logic                  upd;

	// Running maximum and edge one.
	logic [DST_W-1:0]      best_dist_q;
	logic [COORD_BITS-1:0] best_x_q, best_y_q;
	logic [COORD_BITS-1:0] e1_x_q, e1_y_q;

	// Result register.
	logic                  out_valid_q;
	logic [FW-1:0]         eo_x_q, eo_y_q, et_x_q, et_y_q;
	logic                  empty_q, ovf_q;
	logic [EXT_W-1:0]      e1x_ext, e1y_ext, bx_ext, by_ext;

	// Input coordinates narrowed or widened to the internal width.
	assign px_ext = EXT_W'(point_x);
	assign py_ext = EXT_W'(point_y);
	assign x_in   = px_ext[COORD_BITS-1:0];
	assign y_in   = py_ext[COORD_BITS-1:0];
	assign room   = (cnt_q < CNT_W'(MAX_POINTS));

	// Status toward the controller.
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.last_issue = (CNT_W'(rd_addr_q) == (cnt_q - CNT_W'(1)));
	assign stat.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5);
	assign stat.out_free   = !out_valid_q || !out_stall;

	// Store write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			store_q[cnt_q[AW-1:0]] <= {y_in, x_in};
		end
		if (cmd.issue) begin
			rd_s1 <= store_q[rd_addr_q];
		end
	end

	// Point count, sums and overflow mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.load) begin
			if (room) begin
				cnt_q   <= cnt_q + CNT_W'(1);
				sum_x_q <= sum_x_q + DW'(x_in);
				sum_y_q <= sum_y_q + DW'(y_in);
			end else begin
				drop_q <= 1'b1;
			end
		end else if (cmd.emit) begin
			cnt_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			drop_q  <= 1'b0;
		end
	end

	// Read address and pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
		end else begin
			if (cmd.pass_start) begin
				rd_addr_q <= '0;
			end else if (cmd.issue) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage two: scale by the count for the centroid pass.
	assign x_s1   = rd_s1[COORD_BITS-1:0];
	assign y_s1   = rd_s1[2*COORD_BITS-1:COORD_BITS];
	assign prod_x = cmd.pass_two ? DW'(x_s1) : DW'(cnt_q) * DW'(x_s1);
	assign prod_y = cmd.pass_two ? DW'(y_s1) : DW'(cnt_q) * DW'(y_s1);

	// Stage three: distance from the reference point.
	assign ref_x = cmd.pass_two ? DW'(e1_x_q) : sum_x_q;
	assign ref_y = cmd.pass_two ? DW'(e1_y_q) : sum_y_q;

	// Stage four: squares, kept to at most a 64-bit word.
	assign sqx_full = SQF_W'(dx_s3) * SQF_W'(dx_s3);
	assign sqy_full = SQF_W'(dy_s3) * SQF_W'(dy_s3);

	// The first point always seeds the centroid pass; later ones must win strictly.
	assign upd = v_s5 && ((dist_s5 > best_dist_q) || (!cmd.pass_two && first_s5));

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		first_s1  <= (rd_addr_q == '0);
		first_s2  <= first_s1;
		first_s3  <= first_s2;
		first_s4  <= first_s3;
		first_s5  <= first_s4;
		x_s2      <= x_s1;
		y_s2      <= y_s1;
		prod_x_s2 <= prod_x;
		prod_y_s2 <= prod_y;
		x_s3      <= x_s2;
		y_s3      <= y_s2;
		dx_s3     <= (prod_x_s2 >= ref_x) ? prod_x_s2 - ref_x : ref_x - prod_x_s2;
		dy_s3     <= (prod_y_s2 >= ref_y) ? prod_y_s2 - ref_y : ref_y - prod_y_s2;
		x_s4      <= x_s3;
		y_s4      <= y_s3;
		sqx_s4    <= sqx_full[SQ_W-1:0];
		sqy_s4    <= sqy_full[SQ_W-1:0];
		x_s5      <= x_s4;
		y_s5      <= y_s4;
		dist_s5   <= DST_W'(sqx_s4) + DST_W'(sqy_s4);
	end

	// Running maximum; its point becomes edge one after the first pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= '0;
		end else if (cmd.pass_start) begin
			best_dist_q <= '0;
		end else if (upd) begin
			best_dist_q <= dist_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			best_x_q <= x_s5;
			best_y_q <= y_s5;
		end
		if (cmd.latch_e1) begin
			e1_x_q <= best_x_q;
			e1_y_q <= best_y_q;
		end
	end

	// Result register.
	assign e1x_ext = EXT_W'(e1_x_q);
	assign e1y_ext = EXT_W'(e1_y_q);
	assign bx_ext  = EXT_W'(best_x_q);
	assign by_ext  = EXT_W'(best_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			empty_q <= stat.cnt_zero;
			ovf_q   <= drop_q;
			if (stat.cnt_zero) begin
				eo_x_q <= '0;
				eo_y_q <= '0;
				et_x_q <= '0;
				et_y_q <= '0;
			end else begin
				eo_x_q <= e1x_ext[FW-1:0];
				eo_y_q <= e1y_ext[FW-1:0];
				et_x_q <= bx_ext[FW-1:0];
				et_y_q <= by_ext[FW-1:0];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign edge_one_x    = eo_x_q;
	assign edge_one_y    = eo_y_q;
	assign edge_two_x    = et_x_q;
	assign edge_two_y    = et_y_q;
	assign empty_flag    = empty_q;
	assign overflow_flag = ovf_q;

endmodule

@@ sv/contour_farthest_point_pair_top.sv @@
// ----------------------------------------------------------------------------
// contour_farthest_point_pair_top: farthest-point pair of a contour
// Loads contour points, then finds the point farthest from the centroid and
// the point farthest from that one, using exact integer squared distances.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions carry one point each (point_x, point_y, last_point) and
// are taken one per cycle while a contour loads. The transaction with
// last_point set closes the contour; in_stall then stays high while two
// passes run over the stored points, one point read per cycle from the
// single-port point store into a five-stage distance pipeline.
// After the closing transaction both passes run and drain before the result
// is registered. Points beyond MAX_POINTS are dropped and reported through
// overflow_flag.
// The result is one output transaction held in an output register; while
// out_stall is high it holds, and the block already takes the points of the
// next contour, waiting only before it would write a second result.
// Reset clears the point count, sums, sequencer and output valid; the store
// needs no clearing, as only entries written for the current contour are read.
// ----------------------------------------------------------------------------
module contour_farthest_point_pair_top #(
	parameter int MAX_POINTS = cfpp_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = cfpp_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [cfpp_pkg::FIELD_W-1:0] point_x,
	input  logic [cfpp_pkg::FIELD_W-1:0] point_y,
	input  logic                         last_point,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cfpp_pkg::FIELD_W-1:0] edge_one_x,
	output logic [cfpp_pkg::FIELD_W-1:0] edge_one_y,
	output logic [cfpp_pkg::FIELD_W-1:0] edge_two_x,
	output logic [cfpp_pkg::FIELD_W-1:0] edge_two_y,
	output logic                         empty_flag,
	output logic                         overflow_flag
);

	cfpp_pkg::cfpp_cmd_t  cmd;
	cfpp_pkg::cfpp_stat_t stat;

	// Sequencer.
	cfpp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_point (last_point),
		.stat       (stat),
		.in_stall   (in_stall),
		.cmd        (cmd)
	);

	// Point store, distance pipeline and result register.
	cfpp_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.point_x       (point_x),
		.point_y       (point_y),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.edge_one_x    (edge_one_x),
		.edge_one_y    (edge_one_y),
		.edge_two_x    (edge_two_x),
		.edge_two_y    (edge_two_y),
		.empty_flag    (empty_flag),
		.overflow_flag (overflow_flag)
	);

endmodule

@@ verif/contour_farthest_point_pair_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contour_farthest_point_pair_top_tb: self-checking bench of the pair finder
// Sends contours one point per transaction and predicts each closing result
// with an exact integer model of the two farthest-point passes. Each output
// transaction is compared field by field in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module contour_farthest_point_pair_top_tb;

	localparam int CW            = cfpp_pkg::FIELD_W;
	localparam int CAPACITY      = cfpp_pkg::MAX_POINTS_DEF;
	localparam int N_RANDOM      = 800;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 64;

	// One expected result of a closed contour.
	typedef struct packed {
		logic [CW-1:0] one_x;
		logic [CW-1:0] one_y;
		logic [CW-1:0] two_x;
		logic [CW-1:0] two_y;
		logic          empty;
		logic          overflow;
	} point_pair_t;

	// Shapes of random contours.
	typedef enum int {
		SPREAD,
		CLUSTER,
		SAME_POINT,
		CORNERS
	} point_style_t;

	logic          clk        = 1'b0;
	logic          arst_n     = 1'b0;
	logic          in_valid   = 1'b0;
	logic          in_stall;
	logic [CW-1:0] point_x    = '0;
	logic [CW-1:0] point_y    = '0;
	logic          last_point = 1'b0;
	logic          out_valid;
	logic          out_stall  = 1'b0;
	logic [CW-1:0] edge_one_x;
	logic [CW-1:0] edge_one_y;
	logic [CW-1:0] edge_two_x;
	logic [CW-1:0] edge_two_y;
	logic          empty_flag;
	logic          overflow_flag;

	// Predicted contour state.
	logic [CW-1:0]   contour_x [CAPACITY];
	logic [CW-1:0]   contour_y [CAPACITY];
	int unsigned     contour_len = 0;
	longint unsigned total_x     = 0;
	longint unsigned total_y     = 0;
	bit              points_lost = 1'b0;
	point_pair_t     pending_pairs[$];

	int unsigned error_count = 0;
	int unsigned sent_count  = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_left   = 0;
	bit          idle_on     = 1'b1;

	contour_farthest_point_pair_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.point_x       (point_x),
		.point_y       (point_y),
		.last_point    (last_point),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.edge_one_x    (edge_one_x),
		.edge_one_y    (edge_one_y),
		.edge_two_x    (edge_two_x),
		.edge_two_y    (edge_two_y),
		.empty_flag    (empty_flag),
		.overflow_flag (overflow_flag)
	);

	// The clock runs at 100 MHz.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Finds edge one by the scaled centroid distance and edge two by the plain
	// squared distance from edge one. Ties keep the earliest point.
	function automatic point_pair_t farthest_pair();
		point_pair_t     res;
		longint unsigned sx, sy, dx, dy, d_plain, best_plain;
		logic [64:0]     d_scaled, best_scaled;
		int unsigned     i, one_idx, two_idx;
		res = '0;
		if (contour_len == 0) begin
			res.empty = 1'b1;
		end else begin
			best_scaled = '0;
			one_idx     = 0;
			for (i = 0; i < contour_len; i++) begin
				sx = 64'(contour_len) * 64'(contour_x[i]);
				sy = 64'(contour_len) * 64'(contour_y[i]);
				dx = (sx >= total_x) ? sx - total_x : total_x - sx;
				dy = (sy >= total_y) ? sy - total_y : total_y - sy;
				d_scaled = {1'b0, dx * dx} + {1'b0, dy * dy};
				if (d_scaled > best_scaled) begin
					best_scaled = d_scaled;
					one_idx     = i;
				end
			end
			best_plain = 0;
			two_idx    = one_idx;
			for (i = 0; i < contour_len; i++) begin
				sx = 64'(contour_x[i]);
				sy = 64'(contour_y[i]);
				dx = (sx >= 64'(contour_x[one_idx])) ? sx - 64'(contour_x[one_idx])
				                                     : 64'(contour_x[one_idx]) - sx;
				dy = (sy >= 64'(contour_y[one_idx])) ? sy - 64'(contour_y[one_idx])
				                                     : 64'(contour_y[one_idx]) - sy;
				d_plain = dx * dx + dy * dy;
				if (d_plain > best_plain) begin
					best_plain = d_plain;
					two_idx    = i;
				end
			end
			res.one_x = contour_x[one_idx];
			res.one_y = contour_y[one_idx];
			res.two_x = contour_x[two_idx];
			res.two_y = contour_y[two_idx];
		end
		res.overflow = points_lost;
		return res;
	endfunction

	// Stores one accepted point, or drops it when the store is full. A closing
	// point queues the expected pair and starts a new contour.
	function automatic void add_point(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
		if (contour_len < CAPACITY) begin
			contour_x[contour_len] = x;
			contour_y[contour_len] = y;
			contour_len++;
			total_x += x;
			total_y += y;
		end else begin
			points_lost = 1'b1;
		end
		if (last) begin
			pending_pairs.insert(pending_pairs.size(), farthest_pair());
			contour_len = 0;
			total_x     = 0;
			total_y     = 0;
			points_lost = 1'b0;
		end
	endfunction

	// Sends one point after a random gap and waits until the transaction is
	// taken. Called and returning at a rising edge.
	task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		point_x    <= x;
		point_y    <= y;
		last_point <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
		add_point(x, y, last);
	endtask

	function automatic void check_field(string name, logic [CW-1:0] want,
	                                    logic [CW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Each output transaction is compared with the oldest expected pair.
	always @(posedge clk) begin
		point_pair_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pairs.size() == 0) begin
				$display("%0t: result with no closed contour, expected none actual %0d,%0d",
				         $time, edge_one_x, edge_one_y);
				error_count++;
			end else begin
				want = pending_pairs.pop_front();
				check_field("edge_one_x", want.one_x, edge_one_x);
				check_field("edge_one_y", want.one_y, edge_one_y);
				check_field("edge_two_x", want.two_x, edge_two_x);
				check_field("edge_two_y", want.two_y, edge_two_y);
				check_field("empty_flag", want.empty, empty_flag);
				check_field("overflow_flag", want.overflow, overflow_flag);
			end
		end
	end

	// The receiver stalls for a random number of cycles after each result.
	always @(posedge clk) begin
		int unsigned n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else if (out_valid && !out_stall) begin
			n = idle_on ? $urandom_range(0, 11) : 0;
			hold_left <= n;
			out_stall <= (n != 0);
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
		end else begin
			hold_left <= 0;
			out_stall <= 1'b0;
		end
	end

	// The run ends with a failure if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("contour_farthest_point_pair_top: mismatch");
			$finish;
		end
	end

	// Single points at the coordinate extremes, a pair and a three-point contour.
	task automatic test_extremes();
		idle_on = 1'b1;
		send_point('0, '0, 1'b1);
		send_point('1, '1, 1'b1);
		send_point('0, '0, 1'b0);
		send_point('1, '1, 1'b1);
		send_point('1, '0, 1'b0);
		send_point('0, '1, 1'b0);
		send_point(12'd2048, 12'd7, 1'b1);
	endtask

	// All points at the centroid, and equal distances that must keep the first.
	task automatic test_centroid_and_ties();
		idle_on = 1'b0;
		repeat (3) send_point(12'd1234, 12'd2345, 1'b0);
		send_point(12'd1234, 12'd2345, 1'b1);
		idle_on = 1'b1;
		send_point(12'd100, 12'd100, 1'b0);
		send_point(12'd300, 12'd100, 1'b0);
		send_point(12'd300, 12'd300, 1'b0);
		send_point(12'd100, 12'd300, 1'b1);
		send_point(12'd500, 12'd500, 1'b0);
		send_point(12'd700, 12'd500, 1'b0);
		send_point(12'd600, 12'd500, 1'b1);
	endtask

	// A contour longer than the store; the closing point itself is dropped.
	// The next contour must report no overflow.
	task automatic test_store_full();
		int unsigned i;
		for (i = 0; i < CAPACITY + 3; i++) begin
			idle_on = (i >= CAPACITY / 2);
			send_point(CW'($urandom), CW'($urandom), (i == CAPACITY + 2));
		end
		send_point(12'd9, 12'd4000, 1'b0);
		send_point(12'd4000, 12'd9, 1'b1);
	endtask

	// Random contours of mostly short length in several shapes.
	task automatic test_random_contours();
		int unsigned   goal, len, i, base_x, base_y;
		point_style_t  style;
		logic [CW-1:0] x, y;
		goal = sent_count + N_RANDOM;
		while (sent_count < goal) begin
			idle_on = ($urandom_range(0, 3) != 0);
			len     = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160)
			                                      : $urandom_range(1, 24);
			style   = point_style_t'($urandom_range(0, 3));
			base_x  = $urandom_range(0, 4092);
			base_y  = $urandom_range(0, 4092);
			for (i = 0; i < len; i++) begin
				case (style)
					SPREAD: begin
						x = CW'($urandom);
						y = CW'($urandom);
					end
					CLUSTER: begin
						x = CW'(base_x + $urandom_range(0, 3));
						y = CW'(base_y + $urandom_range(0, 3));
					end
					SAME_POINT: begin
						x = CW'(base_x);
						y = CW'(base_y);
					end
					default: begin
						x = $urandom_range(0, 1) ? '1 : '0;
						y = $urandom_range(0, 1) ? '1 : '0;
					end
				endcase
				send_point(x, y, (i == len - 1));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_centroid_and_ties();
		test_store_full();
		test_random_contours();
		in_valid <= 1'b0;
		idle_on = 1'b1;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("contour_farthest_point_pair_top: match");
		end else begin
			$display("contour_farthest_point_pair_top: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/cfpp_pkg.sv
sv/cfpp_ctrl.sv
sv/cfpp_dp.sv
sv/contour_farthest_point_pair_top.sv
verif/contour_farthest_point_pair_top_tb.sv
